[rtl/core/pjts_pkg.sv]
// shared types, codes and constants of the job and timeout scheduler
package pjts_pkg;

  localparam logic [26:0] DAY_MS   = 27'd86400000;
  localparam logic [7:0]  DAY_WRAP = 8'd255;

  // command codes
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_SET_TO = 3'd3;
  localparam logic [2:0] FUNC_DEL_TO = 3'd4;
  localparam logic [2:0] FUNC_CLEAR  = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_JOB  = 2'd0;
  localparam logic [1:0] KIND_TO   = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOTFD = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LEN1,      // length partial products
    S_LEN2,
    S_DECODE,
    S_TICK_RUN,  // update run timer
    S_JOB_RD,    // read job entry
    S_JOB_DIV,   // iterative modulo
    S_JOB_EMIT,
    S_TO_RD,
    S_TO_EMIT,
    S_ADD_FIND,
    S_ADD_SHIFT,
    S_ADD_WR,
    S_RM_FIND,
    S_RM_SHIFT,
    S_ST_FIND,
    S_ST_WR,
    S_TD_FIND,
    S_TD_SHIFT,
    S_DONE
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic       cap;        // capture input item
    logic       len1;
    logic       len2;
    logic       tick_time;  // advance clocks
    logic       run_upd;    // restart check of run timer
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_top;    // idx = count (shift start)
    logic       job_rd;
    logic       div_start;
    logic       div_step;
    logic       to_rd;
    logic       to_dec;     // write back decremented timeout
    logic       job_shift_up;
    logic       job_shift_dn;
    logic       job_wr_new;
    logic       job_cnt_inc;
    logic       job_cnt_dec;
    logic       job_clear;
    logic       to_shift_dn;
    logic       to_wr_len;
    logic       to_wr_new;
    logic       to_cnt_dec;
    logic       emit;
    logic [1:0] kind;
    logic [1:0] status;
    logic       use_id;     // fired_id from entry, else from item/nid
    logic       last;
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic [2:0] func;
    logic       job_any;    // job_count > 0 and run >= period[0]
    logic       job_full;
    logic       to_full;
    logic       idx_lt_jobs;
    logic       idx_lt_tos;
    logic       idx_gt_pos;
    logic       idx_eq_zero;
    logic       ent_le_run; // job period <= run timer
    logic       ent_fire;   // remainder zero and period != 0
    logic       div_done;
    logic       ent_lt_len; // job period < length
    logic       job_id_hit;
    logic       to_id_hit;
    logic       to_zero;    // decremented timeout is zero
  } sts_t;

endpackage

[rtl/core/pjts_ctrl.sv]
// controller state machine of the scheduler
module pjts_ctrl
  import pjts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_LEN1;
      S_LEN1:    state_next = S_LEN2;
      S_LEN2:    state_next = S_DECODE;
      S_DECODE: begin
        priority case (sts.func)
          FUNC_TICK:   state_next = S_TICK_RUN;
          FUNC_ADD:    state_next = sts.job_full ? S_DONE : S_ADD_FIND;
          FUNC_REMOVE: state_next = S_RM_FIND;
          FUNC_SET_TO: state_next = S_ST_FIND;
          FUNC_DEL_TO: state_next = S_TD_FIND;
          default:     state_next = S_DONE;
        endcase
      end
      S_TICK_RUN: state_next = sts.job_any ? S_JOB_RD : S_TO_RD;
      S_JOB_RD: begin
        if (sts.idx_lt_jobs) state_next = S_JOB_DIV;
        else                 state_next = S_TO_RD;
      end
      S_JOB_DIV: begin
        if (!sts.ent_le_run)   state_next = S_TO_RD;
        else if (sts.div_done) state_next = S_JOB_EMIT;
      end
      S_JOB_EMIT: state_next = S_JOB_RD;
      S_TO_RD:    state_next = sts.idx_lt_tos ? S_TO_EMIT : S_DONE;
      S_TO_EMIT:  state_next = S_TO_RD;
      S_ADD_FIND: begin
        if (!(sts.idx_lt_jobs && sts.ent_lt_len)) state_next = S_ADD_SHIFT;
      end
      S_ADD_SHIFT: if (!sts.idx_gt_pos) state_next = S_ADD_WR;
      S_ADD_WR:   state_next = S_DONE;
      S_RM_FIND: begin
        if (!sts.idx_lt_jobs)    state_next = S_DONE;
        else if (sts.job_id_hit) state_next = S_RM_SHIFT;
      end
      S_RM_SHIFT: if (!sts.idx_lt_jobs) state_next = S_DONE;
      S_ST_FIND: begin
        if (!sts.idx_lt_tos || sts.to_id_hit) state_next = S_ST_WR;
      end
      S_ST_WR:    state_next = S_DONE;
      S_TD_FIND: begin
        if (!sts.idx_lt_tos)    state_next = S_DONE;
        else if (sts.to_id_hit) state_next = S_TD_SHIFT;
      end
      S_TD_SHIFT: if (!sts.idx_lt_tos) state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // status of the final item is latched by the datapath in done_st
  // outputs
  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cmd.cap = start;
      S_LEN1:   cmd.len1 = 1'b1;
      S_LEN2:   cmd.len2 = 1'b1;
      S_DECODE: begin
        cmd.idx_clr = 1'b1;
        if (sts.func == FUNC_TICK) cmd.tick_time = 1'b1;
        if (sts.func == FUNC_CLEAR) cmd.job_clear = 1'b1;
        if (sts.func == FUNC_ADD && sts.job_full) cmd.status = ST_FULL;
      end
      S_TICK_RUN: cmd.run_upd = 1'b1;
      S_JOB_RD: begin
        if (sts.idx_lt_jobs) cmd.job_rd = 1'b1;
        else cmd.idx_clr = 1'b1;
      end
      S_JOB_DIV: begin
        if (!sts.ent_le_run) cmd.idx_clr = 1'b1;
        else if (!sts.div_done) cmd.div_step = 1'b1;
      end
      S_JOB_EMIT: begin
        cmd.idx_inc = 1'b1;
        cmd.emit = sts.ent_fire;
        cmd.kind = KIND_JOB;
        cmd.use_id = 1'b1;
      end
      S_TO_RD:   if (sts.idx_lt_tos) cmd.to_rd = 1'b1;
      S_TO_EMIT: begin
        cmd.to_dec = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.emit = sts.to_zero;
        cmd.kind = KIND_TO;
        cmd.use_id = 1'b1;
      end
      S_ADD_FIND: begin
        if (sts.idx_lt_jobs && sts.ent_lt_len) cmd.idx_inc = 1'b1;
        else cmd.idx_top = 1'b1;
      end
      S_ADD_SHIFT: begin
        if (sts.idx_gt_pos) begin
          cmd.job_shift_up = 1'b1;
          cmd.idx_dec = 1'b1;
        end
      end
      S_ADD_WR: begin
        cmd.job_wr_new = 1'b1;
        cmd.job_cnt_inc = 1'b1;
      end
      S_RM_FIND: begin
        if (!sts.idx_lt_jobs) cmd.status = ST_NOTFD;
        else if (!sts.job_id_hit) cmd.idx_inc = 1'b1;
      end
      S_RM_SHIFT: begin
        if (sts.idx_lt_jobs) begin
          cmd.job_shift_dn = 1'b1;
          cmd.idx_inc = 1'b1;
        end else cmd.job_cnt_dec = 1'b1;
      end
      S_ST_FIND: if (sts.idx_lt_tos && !sts.to_id_hit) cmd.idx_inc = 1'b1;
      S_ST_WR: begin
        if (sts.idx_lt_tos) cmd.to_wr_len = 1'b1;
        else if (sts.to_full) cmd.status = ST_FULL;
        else cmd.to_wr_new = 1'b1;
      end
      S_TD_FIND: begin
        if (!sts.idx_lt_tos) cmd.status = ST_NOTFD;
        else if (!sts.to_id_hit) cmd.idx_inc = 1'b1;
      end
      S_TD_SHIFT: begin
        if (sts.idx_lt_tos) begin
          cmd.to_shift_dn = 1'b1;
          cmd.idx_inc = 1'b1;
        end else cmd.to_cnt_dec = 1'b1;
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_DONE;
        cmd.last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/pjts_dp.sv]
// datapath of the scheduler: clocks, tables, modulo unit and result register
module pjts_dp
  import pjts_pkg::*;
#(
  parameter int MAX_JOBS     = 16,
  parameter int MAX_TIMEOUTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  func,
  input  logic [7:0]  id,
  input  logic [15:0] ms,
  input  logic [15:0] sec,
  input  logic [9:0]  minutes,
  input  logic [9:0]  hours,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        done,
  output logic [1:0]  kind,
  output logic [7:0]  fired_id,
  output logic [1:0]  status,
  output logic [26:0] day_millis,
  output logic [7:0]  days,
  output logic        last
);

  localparam int JW = $clog2(MAX_JOBS + 1);
  localparam int TW = $clog2(MAX_TIMEOUTS + 1);
  localparam int JA = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int TA = (MAX_TIMEOUTS > 1) ? $clog2(MAX_TIMEOUTS) : 1;
  localparam int IW = (JW > TW) ? JW : TW;

  // captured item
  logic [2:0]  f_q;
  logic [7:0]  id_q;
  logic [15:0] ms_q, sec_q;
  logic [9:0]  min_q, hr_q;
  logic [31:0] p_sec, p_min, p_hr, len;

  // state
  logic [26:0] millis_of_day;
  logic [7:0]  day_count, next_ident;
  logic [31:0] run_timer;
  logic [JW-1:0] job_count;
  logic [TW-1:0] timeout_count;
  logic [31:0] job_period [MAX_JOBS];
  logic [7:0]  job_ident  [MAX_JOBS];
  logic [31:0] timeout_left  [MAX_TIMEOUTS];
  logic [7:0]  timeout_ident [MAX_TIMEOUTS];
  logic [IW-1:0] idx;
  logic [1:0]  done_st;

  // entry register and modulo unit
  logic [31:0] ent_p, ent_to;
  logic [7:0]  ent_id;
  logic [32:0] rem;
  logic [5:0]  bitn;
  logic        div_busy;

  logic [JA-1:0] ja, jb;
  logic [TA-1:0] ta, tb;
  logic [31:0] first_p, top_p, dec_to;
  logic [32:0] rem_sh, rem_sub;

  assign ja = idx[JA-1:0];
  assign jb = JA'(idx - IW'(1));
  assign ta = idx[TA-1:0];
  assign tb = TA'(idx + IW'(1));
  assign first_p = job_period[0];
  assign top_p = job_period[JA'(job_count - JW'(1))];
  assign dec_to = (ent_to != 32'd0) ? ent_to - 32'd1 : 32'd0;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem[31:0], run_timer[bitn[4:0]]};
  assign rem_sub = rem_sh - {1'b0, ent_p};

  // item capture and length
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      f_q <= func; id_q <= id; ms_q <= ms; sec_q <= sec;
      min_q <= minutes; hr_q <= hours;
    end
    if (cmd.len1) begin
      p_sec <= 32'(sec_q) * 32'd1000;
      p_min <= 32'(min_q) * 32'd60000;
      p_hr  <= 32'(hr_q) * 32'd3600000;
    end
    if (cmd.len2) len <= 32'(ms_q) + p_sec + p_min + p_hr;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      millis_of_day <= '0; day_count <= '0; run_timer <= '0;
      job_count <= '0; timeout_count <= '0; next_ident <= 8'd1;
      done <= 1'b0; idx <= '0; done_st <= ST_OK; div_busy <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.cap) done_st <= ST_OK;
      else if (cmd.status != ST_OK) done_st <= cmd.status;
      if (cmd.tick_time) begin
        run_timer <= run_timer + 32'd1;
        if (millis_of_day + 27'd1 >= DAY_MS) begin
          millis_of_day <= '0;
          day_count <= (day_count + 8'd1 >= DAY_WRAP) ? 8'd0 : day_count + 8'd1;
        end else millis_of_day <= millis_of_day + 27'd1;
      end
      if (cmd.run_upd && sts.job_any && run_timer > top_p) run_timer <= 32'd1;
      priority if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_top) idx <= IW'(job_count);
      else if (cmd.idx_inc) idx <= idx + IW'(1);
      else if (cmd.idx_dec) idx <= idx - IW'(1);
      if (cmd.job_clear) job_count <= '0;
      if (cmd.job_cnt_inc) begin
        job_count <= job_count + JW'(1);
        next_ident <= next_ident + 8'd1;
      end
      if (cmd.job_cnt_dec) job_count <= job_count - JW'(1);
      if (cmd.to_wr_new) timeout_count <= timeout_count + TW'(1);
      if (cmd.to_cnt_dec) timeout_count <= timeout_count - TW'(1);
      if (cmd.job_rd) begin
        div_busy <= 1'b1;
        bitn <= 6'd31;
        rem <= '0;
      end else if (cmd.div_step) begin
        if (bitn == 6'd0) div_busy <= 1'b0;
        bitn <= bitn - 6'd1;
        rem <= rem_sub[32] ? rem_sh : rem_sub;
      end
    end
  end

  // tables
  always_ff @(posedge clk) begin
    if (cmd.job_rd) begin
      ent_p <= job_period[ja];
      ent_id <= job_ident[ja];
    end
    if (cmd.to_rd) begin
      ent_to <= timeout_left[ta];
      ent_id <= timeout_ident[ta];
    end
    if (cmd.job_shift_up) begin
      job_period[ja] <= job_period[jb];
      job_ident[ja] <= job_ident[jb];
    end
    if (cmd.job_shift_dn && (idx + IW'(1) < IW'(job_count))) begin
      job_period[ja] <= job_period[JA'(idx + IW'(1))];
      job_ident[ja] <= job_ident[JA'(idx + IW'(1))];
    end
    if (cmd.job_wr_new) begin
      job_period[ja] <= len;
      job_ident[ja] <= next_ident;
    end
    if (cmd.to_dec) timeout_left[ta] <= dec_to;
    if (cmd.to_shift_dn && (idx + IW'(1) < IW'(timeout_count))) begin
      timeout_left[ta] <= timeout_left[tb];
      timeout_ident[ta] <= timeout_ident[tb];
    end
    if (cmd.to_wr_len) timeout_left[ta] <= len;
    if (cmd.to_wr_new) begin
      timeout_left[ta] <= len;
      timeout_ident[ta] <= id_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind <= cmd.kind;
      last <= cmd.last;
      status <= cmd.last ? done_st : ST_OK;
      day_millis <= millis_of_day;
      days <= day_count;
      if (cmd.use_id) fired_id <= ent_id;
      else if (f_q == FUNC_ADD && done_st == ST_OK) fired_id <= next_ident - 8'd1;
      else if (f_q == FUNC_REMOVE || f_q == FUNC_SET_TO || f_q == FUNC_DEL_TO ||
               f_q == FUNC_ADD) fired_id <= (f_q == FUNC_ADD) ? 8'd0 : id_q;
      else fired_id <= 8'd0;
    end
  end

  // status
  always_comb begin
    sts.func        = f_q;
    sts.job_any     = (job_count != '0) && (run_timer >= first_p);
    sts.job_full    = (job_count >= JW'(MAX_JOBS));
    sts.to_full     = (timeout_count >= TW'(MAX_TIMEOUTS));
    sts.idx_lt_jobs = (idx < IW'(job_count));
    sts.idx_lt_tos  = (idx < IW'(timeout_count));
    sts.idx_gt_pos  = (idx != '0) && (job_period[jb] >= len);
    sts.idx_eq_zero = (idx == '0);
    sts.ent_le_run  = (ent_p <= run_timer);
    sts.div_done    = !div_busy;
    sts.ent_fire    = (ent_p != 32'd0) && (rem == 33'd0);
    sts.ent_lt_len  = (job_period[ja] < len);
    sts.job_id_hit  = (job_ident[ja] == id_q);
    sts.to_id_hit   = (timeout_ident[ta] == id_q);
    sts.to_zero     = (dec_to == 32'd0);
  end

endmodule

[rtl/core/periodic_job_and_timeout_scheduler.sv]
// top level of the millisecond job and timeout scheduler
// Usage: drive func, id, ms, sec, minutes and hours and raise start while
// busy is low; the item is taken at that edge and busy stays high until the
// final result has gone out. Results appear on kind, fired_id, status,
// day_millis, days and last for one cycle each, marked by done; the receiver
// cannot stall them. A tick gives one result per fired job, one per expired
// timeout, then a done result with last set; other commands give one.
// Add, remove and the timeout commands search their table entry by entry. A
// tick runs the 32-step modulo unit on each job whose period is not above the
// run timer (it divides the run timer by the period, one quotient bit a
// cycle), then reads, decrements and checks each timeout.
// Reset clears the clock, day count, run timer and both table counts and sets the
// next job id to 1; no clearing pass is needed.
module periodic_job_and_timeout_scheduler
  import pjts_pkg::*;
#(
  parameter int MAX_JOBS     = 16,
  parameter int MAX_TIMEOUTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [7:0]  id,
  input  logic [15:0] ms,
  input  logic [15:0] sec,
  input  logic [9:0]  minutes,
  input  logic [9:0]  hours,
  output logic        done,
  output logic [1:0]  kind,
  output logic [7:0]  fired_id,
  output logic [1:0]  status,
  output logic [26:0] day_millis,
  output logic [7:0]  days,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  pjts_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .sts, .cmd
  );

  pjts_dp #(.MAX_JOBS(MAX_JOBS), .MAX_TIMEOUTS(MAX_TIMEOUTS)) u_dp (
    .clk, .rst, .func, .id, .ms, .sec, .minutes, .hours, .cmd, .sts,
    .done, .kind, .fired_id, .status, .day_millis, .days, .last
  );

  // a final result ends the busy period
  assert property (@(posedge clk) disable iff (rst) done && last |-> !busy)
    else $error("busy after final item");

  // no result without an item in progress
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result while idle");

  // fired items never carry a status
  assert property (@(posedge clk) disable iff (rst) done && !last |-> status == ST_OK)
    else $error("status on fire item");

endmodule
